// ===== sv/apq_pkg.sv =====
package apq_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int PRIO_MAX_DEF = 255;
  localparam int ID_BITS_DEF  = 16;

  localparam int ID_W   = 16;
  localparam int PRIO_W = 8;
  localparam int STAT_W = 3;
  localparam int OCC_W  = 5;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_RETRIEVED = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] ST_BADPRIO   = 3'd4;

  localparam logic ACT_INSERT   = 1'b0;
  localparam logic ACT_RETRIEVE = 1'b1;

  typedef struct packed {
    logic              action;
    logic [ID_W-1:0]   entry_id;
    logic [PRIO_W-1:0] entry_priority;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   head_id;
    logic [PRIO_W-1:0] head_priority;
    logic [OCC_W-1:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } slot_t;

  typedef struct packed {
    logic  ins;
    logic  ret;
    slot_t new_slot;
  } cell_ctrl_t;

  function automatic logic [PRIO_W-1:0] age_prio(input logic [PRIO_W-1:0] p);
    age_prio = (p > PRIO_W'(1)) ? p - PRIO_W'(1) : p;
  endfunction

endpackage

// ===== sv/apq_stream_if.sv =====
interface apq_stream_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/apq_cell.sv =====
module apq_cell (
  input  logic              clk,
  input  apq_pkg::cell_ctrl_t ctrl,
  input  logic              occupied,
  input  logic              left_cond,
  input  apq_pkg::slot_t    left_slot,
  input  apq_pkg::slot_t    right_slot,
  output logic              cond,
  output apq_pkg::slot_t    slot
);
  import apq_pkg::*;

  slot_t slot_r;
  slot_t slot_nxt;

  // entry here leaves after the new one
  assign cond = !occupied || (slot_r.prio > ctrl.new_slot.prio);
  assign slot = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (ctrl.ins) begin
      if (left_cond) begin
        slot_nxt = left_slot;
      end else if (cond) begin
        slot_nxt = ctrl.new_slot;
      end
    end else if (ctrl.ret) begin
      slot_nxt.id   = right_slot.id;
      slot_nxt.prio = age_prio(right_slot.prio);
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end
endmodule

// ===== sv/aging_priority_queue_top.sv =====
// channel  | dir | handshake     | payload
// in_chan  | in  | valid / ready | action, entry_id, entry_priority
// out_chan | out | valid / ready | status, head_id, head_priority, occupancy
//
// one request per cycle while out_chan is not stalled; the response is registered
// all cells compare, shift and age in parallel
// in_chan.ready is high while the output register is empty or being taken
// synchronous active-low reset empties the queue and the output register
// a stall on out_chan holds the response and blocks new requests
module aging_priority_queue_top #(
  parameter int DEPTH    = apq_pkg::DEPTH_DEF,
  parameter int PRIO_MAX = apq_pkg::PRIO_MAX_DEF,
  parameter int ID_BITS  = apq_pkg::ID_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  apq_stream_if.sink   in_chan,
  apq_stream_if.source out_chan
);
  import apq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEEP_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam logic [ID_W-1:0] ID_MASK = ID_W'((64'd1 << KEEP_W) - 64'd1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  rsp_t             out_r, out_nxt;

  logic       accept;
  logic       bad_prio, full, empty;
  cell_ctrl_t ctrl;
  logic       cond   [DEPTH];
  slot_t      slots  [DEPTH];
  req_t       req;

  assign req      = in_chan.data;
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept   = in_chan.valid && in_chan.ready;
  assign bad_prio = (req.entry_priority == '0) || (int'(req.entry_priority) > PRIO_MAX);
  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);

  always_comb begin
    ctrl.ins         = accept && (req.action == ACT_INSERT) && !bad_prio && !full;
    ctrl.ret         = accept && (req.action == ACT_RETRIEVE) && !empty;
    ctrl.new_slot.id   = req.entry_id & ID_MASK;
    ctrl.new_slot.prio = req.entry_priority;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic  lc;
    slot_t ls, rs;
    if (i == 0) begin : g_first
      assign lc = 1'b0;
      assign ls = slots[0];
    end else begin : g_mid
      assign lc = cond[i-1];
      assign ls = slots[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rs = slots[i];
    end else begin : g_inner
      assign rs = slots[i+1];
    end
    apq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (cnt_r > CNT_W'(i)),
      .left_cond  (lc),
      .left_slot  (ls),
      .right_slot (rs),
      .cond       (cond[i]),
      .slot       (slots[i])
    );
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (accept) begin
      out_valid_nxt         = 1'b1;
      out_nxt.head_id       = '0;
      out_nxt.head_priority = '0;
      if (req.action == ACT_INSERT) begin
        priority if (bad_prio) begin
          out_nxt.status = ST_BADPRIO;
        end else if (full) begin
          out_nxt.status = ST_FULL;
        end else begin
          out_nxt.status = ST_INSERTED;
          cnt_nxt        = cnt_r + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          out_nxt.status        = ST_RETRIEVED;
          out_nxt.head_id       = slots[0].id;
          out_nxt.head_priority = slots[0].prio;
          cnt_nxt               = cnt_r - CNT_W'(1);
        end
      end
      out_nxt.occupancy = OCC_W'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;
endmodule

// ===== sv/apq_checker.sv =====
module apq_checker #(
  parameter int DEPTH = apq_pkg::DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input apq_pkg::rsp_t out_data
);
  import apq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("response dropped or changed under stall");

  a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("request gave no response");

  a_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_RETRIEVED) |->
      (out_data.head_id == '0) && (out_data.head_priority == '0))
    else $error("head fields set on a non-retrieve response");

  a_retrieved_prio: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_RETRIEVED) |-> (out_data.head_priority != '0))
    else $error("retrieved entry with priority zero");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) |-> (out_data.occupancy == OCC_W'(DEPTH)))
    else $error("full rejection with queue not full");
endmodule

bind aging_priority_queue_top apq_checker #(.DEPTH(DEPTH)) u_apq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);
